### src/imufe_pkg.sv
package imufe_pkg;

  localparam int unsigned NumFields  = 6;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned InWidth    = NumFields * FieldWidth;

  localparam logic [4:0] POS_START     = 5'd0;
  localparam logic [4:0] POS_TYPE      = 5'd1;
  localparam logic [4:0] POS_LEN       = 5'd2;
  localparam logic [4:0] POS_PAY_FIRST = 5'd3;
  localparam logic [4:0] POS_PAY_LAST  = 5'd26;
  localparam logic [4:0] POS_CRC_LO    = 5'd27;
  localparam logic [4:0] POS_CRC_HI    = 5'd28;

  localparam logic [7:0]  PAYLOAD_LEN = 8'd24;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  localparam logic [7:0] START_RESET = 8'hFC;
  localparam logic [7:0] TYPE_RESET  = 8'h01;

  localparam logic REG_START = 1'b0;
  localparam logic REG_TYPE  = 1'b1;

  typedef struct packed {
    logic init;
    logic feed;
  } crc_ctrl_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/imufe_crc16.sv
module imufe_crc16 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imufe_pkg::crc_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  output logic [15:0]          crc_o
);

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = imufe_pkg::CRC_INIT;
    end else if (ctrl_i.feed) begin
      crc_d = imufe_pkg::crc16_byte(crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= imufe_pkg::CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

### src/imu_frame_encoder_crc16.sv
// Channel   Dir  Width  Contents
// s_axis    in   192    one word per reading set, six signed 32-bit fields
// m_axis    out  8      one frame byte per word, tlast on the CRC high byte
// apb       in   32     start_byte at 0x0, frame_type at 0x4
//
// Each input word yields a 29-byte frame, one byte per unstalled cycle through
// the output register; frames with a buffered next word run back to back.
// A one-word input buffer takes the next word while the current frame drains.
// The CRC register advances one byte per emitted type, length and payload byte.
// Reset is asynchronous; the registers return to 0xFC and 0x01.
// An output stall holds the serializer and the CRC in place.
module imu_frame_encoder_crc16 (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] accel_x, [63:32] accel_y, [95:64] accel_z,
  // [127:96] yaw_milli, [159:128] pitch_milli, [191:160] roll_milli
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [7:0] start_q, type_q;
  logic       cfg_wr;

  logic [imufe_pkg::InWidth-1:0] buf_q, sh_q;
  logic                          buf_vld_q, active_q;
  logic [4:0]                    cnt_q;

  logic [7:0] m_data_q;
  logic       m_last_q, m_valid_q;

  logic                 in_acc, out_free, emit, emit_last, load, in_pay;
  logic [7:0]           cur_byte;
  logic [15:0]          crc;
  imufe_pkg::crc_ctrl_t crc_ctrl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == imufe_pkg::REG_TYPE) ? {24'd0, type_q} : {24'd0, start_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= imufe_pkg::START_RESET;
      type_q  <= imufe_pkg::TYPE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == imufe_pkg::REG_TYPE) begin
        type_q <= pwdata[7:0];
      end else begin
        start_q <= pwdata[7:0];
      end
    end
  end

  assign out_free  = !m_valid_q || m_axis_tready;
  assign emit      = active_q && out_free;
  assign emit_last = emit && (cnt_q == imufe_pkg::POS_CRC_HI);
  assign load      = buf_vld_q && (!active_q || emit_last);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_pay    = (cnt_q >= imufe_pkg::POS_PAY_FIRST) && (cnt_q <= imufe_pkg::POS_PAY_LAST);

  assign s_axis_tready = !buf_vld_q || load;

  always_comb begin
    case (cnt_q)
      imufe_pkg::POS_START:  cur_byte = start_q;
      imufe_pkg::POS_TYPE:   cur_byte = type_q;
      imufe_pkg::POS_LEN:    cur_byte = imufe_pkg::PAYLOAD_LEN;
      imufe_pkg::POS_CRC_LO: cur_byte = crc[7:0];
      imufe_pkg::POS_CRC_HI: cur_byte = crc[15:8];
      default:               cur_byte = sh_q[7:0];
    endcase
  end

  always_comb begin
    crc_ctrl.init = load;
    crc_ctrl.feed = emit && (cnt_q >= imufe_pkg::POS_TYPE) && (cnt_q <= imufe_pkg::POS_PAY_LAST);
  end

  imufe_crc16 u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .byte_i (cur_byte),
    .crc_o  (crc)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q <= s_axis_tdata;
    end
    if (load) begin
      sh_q <= buf_q;
    end else if (emit && in_pay) begin
      sh_q <= {8'd0, sh_q[imufe_pkg::InWidth-1:8]};
    end
    if (emit) begin
      m_data_q <= cur_byte;
      m_last_q <= (cnt_q == imufe_pkg::POS_CRC_HI);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_vld_q <= 1'b0;
      active_q  <= 1'b0;
      cnt_q     <= imufe_pkg::POS_START;
      m_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        buf_vld_q <= 1'b1;
      end else if (load) begin
        buf_vld_q <= 1'b0;
      end
      if (load) begin
        active_q <= 1'b1;
        cnt_q    <= imufe_pkg::POS_START;
      end else if (emit_last) begin
        active_q <= 1'b0;
        cnt_q    <= imufe_pkg::POS_START;
      end else if (emit) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= imufe_pkg::POS_CRC_HI)
    else $error("byte counter out of frame");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> buf_vld_q && active_q)
    else $error("input stalled with free buffer");

  a_last_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> m_axis_tvalid && m_axis_tlast)
    else $error("frame end not flagged");

  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last && buf_vld_q |=> active_q && (cnt_q == imufe_pkg::POS_START))
    else $error("next frame not started");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (cnt_q == imufe_pkg::POS_START))
    else $error("counter not cleared when idle");

endmodule

### dv/imufe_frame_checker.sv
module imufe_frame_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready,
  output int           fail_count,
  output int           bytes_pending,
  output int           bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] StartAddr = {imufe_pkg::REG_START, 2'b00};
  localparam logic [2:0] TypeAddr  = {imufe_pkg::REG_TYPE, 2'b00};
  localparam int unsigned FrameBytes = 29;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic [7:0]  start_byte_q;
  logic [7:0]  frame_type_q;
  frame_byte_t frame_bytes_q[$];

  assign bytes_pending = frame_bytes_q.size();

  // serial form of the reflected CRC16: one input bit per shift, LSB first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) begin
        r = {1'b0, r[15:1]} ^ imufe_pkg::CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  task automatic queue_frame(input logic [191:0] readings);
    logic [7:0]  bytes[FrameBytes];
    logic [15:0] crc;
    frame_byte_t fb;
    bytes[0] = start_byte_q;
    bytes[1] = frame_type_q;
    bytes[2] = imufe_pkg::PAYLOAD_LEN;
    for (int k = 0; k < 24; k++) begin
      bytes[3 + k] = readings[8*k +: 8];
    end
    crc = imufe_pkg::CRC_INIT;
    for (int k = 1; k < 27; k++) begin
      crc = modbus_crc_byte(crc, bytes[k]);
    end
    bytes[27] = crc[7:0];
    bytes[28] = crc[15:8];
    for (int k = 0; k < FrameBytes; k++) begin
      fb.data = bytes[k];
      fb.last = (k == FrameBytes - 1);
      frame_bytes_q.push_back(fb);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_byte_t exp_b;
    if (!rst_ni) begin
      start_byte_q = imufe_pkg::START_RESET;
      frame_type_q = imufe_pkg::TYPE_RESET;
      frame_bytes_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == StartAddr) start_byte_q = pwdata[7:0];
          if (paddr == TypeAddr) frame_type_q = pwdata[7:0];
        end else if (paddr == StartAddr && prdata[7:0] !== start_byte_q) begin
          $display("%0t start_byte readback: expected %h actual %h",
                   $time, start_byte_q, prdata[7:0]);
          fail_count++;
        end else if (paddr == TypeAddr && prdata[7:0] !== frame_type_q) begin
          $display("%0t frame_type readback: expected %h actual %h",
                   $time, frame_type_q, prdata[7:0]);
          fail_count++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes_q.size() == 0) begin
          $display("%0t unexpected byte: expected none actual %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          exp_b = frame_bytes_q.pop_front();
          bytes_checked++;
          if (m_axis_tdata !== exp_b.data) begin
            $display("%0t out_byte: expected %h actual %h", $time, exp_b.data, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== exp_b.last) begin
            $display("%0t last_byte: expected %b actual %b", $time, exp_b.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        queue_frame(s_axis_tdata);
      end
    end
  end

  initial begin
    fail_count    = 0;
    bytes_checked = 0;
  end

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] StartAddr  = {imufe_pkg::REG_START, 2'b00};
  localparam logic [2:0] TypeAddr   = {imufe_pkg::REG_TYPE, 2'b00};
  localparam int         CycleLimit = 400000;
  localparam int         PhaseItems = 64;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  int fail_count;
  int bytes_pending;
  int bytes_checked;
  int cycle_count;
  int sets_sent;
  int settings_used;
  bit sender_calm;
  bit sink_calm;

  imu_frame_encoder_crc16 DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  imufe_frame_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count, .bytes_pending, .bytes_checked
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [191:0] pack_set(input logic [31:0] ax, input logic [31:0] ay,
                                            input logic [31:0] az, input logic [31:0] yaw,
                                            input logic [31:0] pitch, input logic [31:0] roll);
    return {roll, pitch, yaw, az, ay, ax};
  endfunction

  function automatic logic [31:0] pick_reading();
    int unsigned sel;
    sel = $urandom_range(0, 11);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4, 5, 6: return 32'($signed($urandom_range(0, 40000)) - 20000);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_set(input logic [191:0] w);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    sets_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drain every queued byte, then leave room for the output register
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [31:0] start_val, input logic [31:0] type_val);
    wait_idle();
    apb_access(1'b1, StartAddr, start_val);
    apb_access(1'b1, TypeAddr, type_val);
    apb_access(1'b0, StartAddr, 32'h0);
    apb_access(1'b0, TypeAddr, 32'h0);
    settings_used++;
  endtask

  task automatic random_sets(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        sender_calm = ($urandom_range(0, 3) == 0);
        sink_calm   = ($urandom_range(0, 3) == 0);
      end
      send_set(pack_set(pick_reading(), pick_reading(), pick_reading(),
                        pick_reading(), pick_reading(), pick_reading()));
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
  endtask

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cycle_count   = 0;
    sets_sent     = 0;
    settings_used = 1;
    sender_calm   = 1'b0;
    sink_calm     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_access(1'b0, StartAddr, 32'h0);
    apb_access(1'b0, TypeAddr, 32'h0);

    send_set({6{32'h0000_0000}});
    send_set({6{32'hFFFF_FFFF}});
    send_set({6{32'h8000_0000}});
    send_set({6{32'h7FFF_FFFF}});
    send_set({6{32'h5555_5555}});
    send_set({6{32'hAAAA_AAAA}});
    send_set(pack_set(32'h0302_0100, 32'h0706_0504, 32'h0B0A_0908,
                      32'h0F0E_0D0C, 32'h1312_1110, 32'h1716_1514));
    send_set(pack_set(32'd1000, -32'sd1000, 32'd9807, 32'd3142, -32'sd1571, 32'd0));
    send_set(pack_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                      32'h1, 32'h8000_0000));
    sender_calm = 1'b1;
    sink_calm   = 1'b1;
    for (int n = 0; n < 4; n++) begin
      send_set({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    end
    sender_calm = 1'b0;
    sink_calm   = 1'b0;
    random_sets(PhaseItems);

    set_registers(32'hABCD_EF00, 32'h1234_5600);
    send_set({6{32'h0000_0000}});
    send_set({6{32'hFFFF_FFFF}});
    random_sets(PhaseItems);

    set_registers(32'h0000_00FF, 32'hFFFF_FFFF);
    send_set({6{32'h0000_0000}});
    send_set({6{32'h8000_0000}});
    random_sets(PhaseItems);

    set_registers($urandom(), $urandom());
    random_sets(PhaseItems / 2);
    set_registers({24'h0, imufe_pkg::START_RESET}, {24'h0, imufe_pkg::TYPE_RESET});
    random_sets(PhaseItems / 2);

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Encoded %0d reading sets under %0d register settings, %0d frame bytes checked.",
             sets_sent, settings_used, bytes_checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
src/imufe_pkg.sv
src/imufe_crc16.sv
src/imu_frame_encoder_crc16.sv
dv/imufe_frame_checker.sv
dv/tb_top.sv
